// File: hw/rtl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// shared types, widths and register codes of the ycbcr to rgb converter
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned COEF_W      = 18;
  localparam int unsigned LANES_MAX   = 4;
  localparam int unsigned PIXEL_LANES_DEF = 4;
  localparam int unsigned PRODUCT_W   = COEF_W + PIX_W;   // 18 x 8 unsigned
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned TERM_MAG_W  = PRODUCT_W - FRAC_W;
  localparam int unsigned TERM_W      = TERM_MAG_W + 1;
  localparam int unsigned SUM_W       = TERM_W + 1;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned IN_DATA_W   = 64;
  localparam int unsigned OUT_DATA_W  = 96;

  localparam logic [COEF_W-1:0] COEF_V_TO_RED_RST   = 18'd91881;
  localparam logic [COEF_W-1:0] COEF_U_TO_GREEN_RST = 18'd22553;
  localparam logic [COEF_W-1:0] COEF_V_TO_GREEN_RST = 18'd46802;
  localparam logic [COEF_W-1:0] COEF_U_TO_BLUE_RST  = 18'd116130;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_V_TO_RED   = 4'd0,
    REG_U_TO_GREEN = 4'd1,
    REG_V_TO_GREEN = 4'd2,
    REG_U_TO_BLUE  = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] v_to_red;
    logic [COEF_W-1:0] u_to_green;
    logic [COEF_W-1:0] v_to_green;
    logic [COEF_W-1:0] u_to_blue;
  } coef_t;

  // chroma terms of one pair, already scaled and truncated toward zero
  typedef struct packed {
    logic signed [TERM_W-1:0] red;
    logic signed [TERM_W-1:0] green_u;
    logic signed [TERM_W-1:0] green_v;
    logic signed [TERM_W-1:0] blue;
  } terms_t;

  typedef struct packed {
    logic [1:0][PIX_W-1:0] luma;
    terms_t                terms;
  } pair_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

endpackage

// File: hw/rtl/y2r_pair.sv
// ----------------------------------------------------------------------------
// y2r_pair
// chroma multipliers of one pair, registered together with the pair's lumas
// ----------------------------------------------------------------------------
module y2r_pair (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  y2r_pkg::coef_t                      coef_i,
  input  logic [1:0][y2r_pkg::PIX_W-1:0]      luma_i,
  input  logic [y2r_pkg::PIX_W-1:0]           u_i,
  input  logic [y2r_pkg::PIX_W-1:0]           v_i,
  output y2r_pkg::pair_t                      pair_o
);
  import y2r_pkg::*;

  logic signed [PIX_W:0] du, dv;
  logic [PIX_W-1:0]      du_mag, dv_mag;
  logic                  du_neg, dv_neg;
  logic [PRODUCT_W-1:0]  p_red, p_gu, p_gv, p_blue;
  terms_t                terms_d;
  pair_t                 pair_q;

  function automatic logic signed [TERM_W-1:0] scale(input logic [PRODUCT_W-1:0] p,
                                                      input logic neg);
    logic signed [TERM_W-1:0] q;
    q = $signed({1'b0, p[PRODUCT_W-1:FRAC_W]});
    return neg ? -q : q;
  endfunction

  always_comb begin
    du     = $signed({1'b0, u_i}) - $signed(9'd128);
    dv     = $signed({1'b0, v_i}) - $signed(9'd128);
    du_neg = du[PIX_W];
    dv_neg = dv[PIX_W];
    // magnitude is at most 128 so it fits in eight bits
    du_mag = du_neg ? PIX_W'(-du) : PIX_W'(du);
    dv_mag = dv_neg ? PIX_W'(-dv) : PIX_W'(dv);
    p_red  = PRODUCT_W'(coef_i.v_to_red)   * PRODUCT_W'(dv_mag);
    p_gu   = PRODUCT_W'(coef_i.u_to_green) * PRODUCT_W'(du_mag);
    p_gv   = PRODUCT_W'(coef_i.v_to_green) * PRODUCT_W'(dv_mag);
    p_blue = PRODUCT_W'(coef_i.u_to_blue)  * PRODUCT_W'(du_mag);
    terms_d.red     = scale(p_red,  dv_neg);
    terms_d.green_u = scale(p_gu,   du_neg);
    terms_d.green_v = scale(p_gv,   dv_neg);
    terms_d.blue    = scale(p_blue, du_neg);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair_q.luma  <= luma_i;
      pair_q.terms <= terms_d;
    end
  end

  assign pair_o = pair_q;

endmodule

// File: hw/rtl/y2r_lane.sv
// ----------------------------------------------------------------------------
// y2r_lane
// one pixel: luma plus chroma terms, clamped to a byte per channel
// ----------------------------------------------------------------------------
module y2r_lane (
  input  logic [y2r_pkg::PIX_W-1:0] luma_i,
  input  y2r_pkg::terms_t           terms_i,
  output y2r_pkg::pixel_t           pixel_o
);
  import y2r_pkg::*;

  logic signed [SUM_W-1:0] y_s, r_sum, g_sum, b_sum;

  function automatic logic [PIX_W-1:0] clamp(input logic signed [SUM_W-1:0] x);
    if (x < 0) begin
      return '0;
    end else if (x > $signed(SUM_W'(255))) begin
      return '1;
    end
    return x[PIX_W-1:0];
  endfunction

  always_comb begin
    y_s   = $signed({{(SUM_W-PIX_W){1'b0}}, luma_i});
    r_sum = y_s + SUM_W'(terms_i.red);
    g_sum = y_s - SUM_W'(terms_i.green_u) - SUM_W'(terms_i.green_v);
    b_sum = y_s + SUM_W'(terms_i.blue);
    pixel_o.red   = clamp(r_sum);
    pixel_o.green = clamp(g_sum);
    pixel_o.blue  = clamp(b_sum);
  end

endmodule

// File: hw/rtl/y2r_merge.sv
// ----------------------------------------------------------------------------
// y2r_merge
// packs the lane pixels into one result word and holds it for the sink
// ----------------------------------------------------------------------------
module y2r_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  y2r_pkg::pixel_t [y2r_pkg::LANES_MAX-1:0]    pixels_i,
  output logic                                        take_o,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [y2r_pkg::OUT_DATA_W-1:0]              m_tdata
);
  import y2r_pkg::*;

  logic                  valid_q, valid_d;
  logic [OUT_DATA_W-1:0] data_q, data_d;

  assign take_o = !valid_q || m_tready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (take_o) begin
      valid_d = valid_i;
      for (int k = 0; k < LANES_MAX; k++) begin
        data_d[24*k +: 8]      = pixels_i[k].red;
        data_d[24*k + 8 +: 8]  = pixels_i[k].green;
        data_d[24*k + 16 +: 8] = pixels_i[k].blue;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_tvalid = valid_q;
  assign m_tdata  = data_q;

endmodule

// File: hw/rtl/yuv420_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter_top
// bt.601 full-range ycbcr 4:2:0 to rgb, four pixels per transaction
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   64     four lumas and two chroma pairs
//  m_axis    out  96     red, green, blue of four pixels
//  cfg       in   18     four q16 chroma gains, write only
//
// one transaction in and one out every clock while m_axis does not stall; a
// result passes the registered chroma multipliers of each pair, then the output register
// reset sets the gains to the bt.601 values and empties the pipeline
// a stall on m_axis holds the output register; s_tready drops only when the
// pipeline stage behind it is full as well
// ----------------------------------------------------------------------------
module yuv420_to_rgb_converter_top #(
  parameter int unsigned PIXEL_LANES = y2r_pkg::PIXEL_LANES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // y_lane0, y_lane1, y_lane2, y_lane3, u_pair0, v_pair0, u_pair1, v_pair1
  input  logic [y2r_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // red_lane0, green_lane0, blue_lane0, ... red_lane3, green_lane3, blue_lane3
  output logic [y2r_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we_i,
  input  logic [y2r_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [y2r_pkg::COEF_W-1:0]         cfg_wdata_i
);
  import y2r_pkg::*;

  // chroma pair k serves lanes 2k and 2k+1
  localparam int unsigned NumPairs = (PIXEL_LANES + 1) / 2;

  coef_t                    coef_q, coef_d;
  logic                     st_a_valid_q;
  logic                     en_a, en_b;
  pair_t [NumPairs-1:0]     pair_q;
  pixel_t [LANES_MAX-1:0]   pixels;

  // gain registers, out-of-range indexes fall through untouched
  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_V_TO_RED:   coef_d.v_to_red   = cfg_wdata_i;
        REG_U_TO_GREEN: coef_d.u_to_green = cfg_wdata_i;
        REG_V_TO_GREEN: coef_d.v_to_green = cfg_wdata_i;
        REG_U_TO_BLUE:  coef_d.u_to_blue  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.v_to_red   <= COEF_V_TO_RED_RST;
      coef_q.u_to_green <= COEF_U_TO_GREEN_RST;
      coef_q.v_to_green <= COEF_V_TO_GREEN_RST;
      coef_q.u_to_blue  <= COEF_U_TO_BLUE_RST;
    end else begin
      coef_q <= coef_d;
    end
  end

  // stage a moves when empty or when the output register takes its word
  assign en_a     = !st_a_valid_q || en_b;
  assign s_tready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_a_valid_q <= 1'b0;
    end else if (en_a) begin
      st_a_valid_q <= s_tvalid;
    end
  end

  // multiplier stage, one unit per chroma pair
  for (genvar p = 0; p < NumPairs; p++) begin : g_pair
    y2r_pair u_pair (
      .clk_i  (clk_i),
      .en_i   (en_a),
      .coef_i (coef_q),
      .luma_i (s_tdata[16*p +: 16]),
      .u_i    (s_tdata[32 + 16*p +: 8]),
      .v_i    (s_tdata[40 + 16*p +: 8]),
      .pair_o (pair_q[p])
    );
  end

  // pixel lanes, lanes past the configured count drive zero
  for (genvar k = 0; k < LANES_MAX; k++) begin : g_lane
    if (k < PIXEL_LANES) begin : g_used
      y2r_lane u_lane (
        .luma_i  (pair_q[k/2].luma[k%2]),
        .terms_i (pair_q[k/2].terms),
        .pixel_o (pixels[k])
      );
    end else begin : g_unused
      assign pixels[k] = '0;
    end
  end

  // merge the lanes into the result word
  y2r_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (st_a_valid_q),
    .pixels_i (pixels),
    .take_o   (en_b),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef ASSERT_OFF
  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // an accepted transaction lands in stage a
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> st_a_valid_q)
    else $error("accepted transaction lost before stage a");

  // a stalled stage a keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_a_valid_q && !en_b |=> st_a_valid_q)
    else $error("stage a dropped a word under stall");

  // a write to the red gain takes effect on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == REG_V_TO_RED |=> coef_q.v_to_red == $past(cfg_wdata_i))
    else $error("red gain write not applied");
`endif

endmodule
